### rtl/pva_pkg.sv
// shared types and constants for the polyphonic voice allocator
// voice table entry, result item, command and operation codes
// no dependencies
package pva_pkg;

    localparam int NOTE_W      = 8;
    localparam int VEL_W       = 7;
    localparam int KEY_W       = 7;
    localparam int VID_W       = 4;
    localparam int OP_W        = 3;
    localparam int CMD_W       = 3;
    localparam int VCOUNT_W    = 5;
    localparam int TRANSPOSE_W = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    localparam int MAX_RESULTS = 16;
    localparam int RES_PTR_W   = 4;
    localparam int RES_CNT_W   = 5;

    localparam logic [VCOUNT_W-1:0]    VCOUNT_RESET    = 5'd16;
    localparam logic [TRANSPOSE_W-1:0] TRANSPOSE_RESET = 6'd24;
    localparam logic [NOTE_W-1:0]      TRANSPOSE_BIAS  = 8'd24;
    localparam logic [KEY_W-1:0]       PEDAL_THRESH    = 7'd63;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON        = 3'd0,
        OP_NOTE_OFF       = 3'd1,
        OP_PEDAL          = 3'd2,
        OP_ALL_SOUND_OFF  = 3'd3,
        OP_ALL_NOTES_OFF  = 3'd4,
        OP_VOICE_SILENT   = 3'd5
    } t_op;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_RELEASE   = 3'd2,
        CMD_SYNC      = 3'd3,
        CMD_LFO       = 3'd4,
        CMD_XSIG      = 3'd5,
        CMD_XSTATE    = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOICE_COUNT = 2'd0,
        CFG_TRANSPOSE   = 2'd1,
        CFG_MONO_MODE   = 2'd2,
        CFG_OSC_SYNC    = 2'd3
    } t_cfg;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic              keydown;
        logic              sustained;
        logic              live;
    } t_voice;

    typedef struct packed {
        t_cmd              command;
        logic [VID_W-1:0]  target;
        logic [VID_W-1:0]  source;
        logic [NOTE_W-1:0] pitch;
        logic [VEL_W-1:0]  vel;
    } t_result;

    typedef struct packed {
        logic push;
        logic push_last;
        logic mark_last;
        logic hold;
    } t_qctl;

endpackage

### rtl/polyphonic_voice_allocator_core.sv
// polyphonic voice allocator: voice table in a synchronous memory, scan sequencer
// one item at a time; an item waits for the result queue to drain, then runs its
// table scans (over the configured voice count, over all VOICES for all-sound-off
// and all-notes-off); results leave one per cycle while the consumer is ready;
// synchronous active-low reset, the table reads as cleared through per-entry
// valid flags, so no clearing pass is needed
module polyphonic_voice_allocator_core import pva_pkg::*; #(
    parameter int VOICES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [OP_W-1:0]        i_operation,
    input  logic [KEY_W-1:0]       i_key,
    input  logic [VEL_W-1:0]       i_velocity,
    input  logic [KEY_W-1:0]       i_pedal_value,
    input  logic [VID_W-1:0]       i_silent_voice,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [CMD_W-1:0]       o_command,
    output logic [VID_W-1:0]       o_target_voice,
    output logic [VID_W-1:0]       o_source_voice,
    output logic [NOTE_W-1:0]      o_voice_pitch,
    output logic [VEL_W-1:0]       o_voice_velocity,
    output logic                   o_last,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_WAIT     = 10'b0000000010,
        S_SCAN     = 10'b0000000100,
        S_UP_VWR   = 10'b0000001000,
        S_UP_TWR   = 10'b0000010000,
        S_DN_START = 10'b0000100000,
        S_DN_SYNC  = 10'b0001000000,
        S_DN_LFO   = 10'b0010000000,
        S_DN_LIVE  = 10'b0100000000,
        S_FINISH   = 10'b1000000000
    } t_state;

    typedef enum logic [2:0] {
        M_UP_FIND   = 3'd0,
        M_UP_MONO   = 3'd1,
        M_DN_FIND   = 3'd2,
        M_DN_MONO   = 3'd3,
        M_PEDAL     = 3'd4,
        M_SOUND_OFF = 3'd5,
        M_NOTES_OFF = 3'd6,
        M_SILENT    = 3'd7
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode;

    logic [VCOUNT_W-1:0]    r_vcount;
    logic [TRANSPOSE_W-1:0] r_transpose;
    logic                   r_mono;
    logic                   r_osc;
    logic [IW-1:0]          r_next;
    logic                   r_pedal;

    t_op                    r_op;
    logic [NOTE_W-1:0]      r_pitch;
    logic [VEL_W-1:0]       r_vel;
    logic [KEY_W-1:0]       r_pedalv;
    logic [VID_W-1:0]       r_silent;

    t_voice                 r_mem [VOICES];
    logic [VOICES-1:0]      r_vld;
    t_voice                 r_rdata;
    logic                   r_rd_vld;
    logic                   r_tag;
    logic [IW-1:0]          r_ridx;

    logic [IW-1:0]          r_addr;
    logic [CW-1:0]          r_iss;
    logic [CW-1:0]          r_chk;
    logic [CW-1:0]          r_len;

    logic [IW-1:0]          r_v;
    logic [IW-1:0]          r_t;
    t_voice                 r_vcap;
    t_voice                 r_tcap;
    logic                   r_hit;
    logic                   r_found;
    logic                   r_busy0;
    logic [NOTE_W-1:0]      r_high;
    logic [RES_CNT_W-1:0]   r_nres;

    logic [7:0]             vc_ext;
    logic [CW-1:0]          eff_cnt;
    t_voice                 ent;
    t_voice                 dn_entry;
    logic                   ev;
    logic                   last_chk;
    logic                   match;
    logic                   cand;
    logic                   scan_end;
    logic                   rd_en;
    logic [IW-1:0]          addr_nx;
    logic                   go_scan;
    t_mode                  go_mode;
    logic [IW-1:0]          go_start;
    logic [CW-1:0]          go_len;
    logic                   mem_we;
    logic [IW-1:0]          mem_wa;
    t_voice                 mem_wd;
    logic                   push_req;
    logic                   push_ok;
    logic                   push_last;
    logic                   mark;
    t_result                push_item;
    t_qctl                  q_ctl;
    logic                   q_empty;
    t_result                q_item;
    logic                   in_acc;

    function automatic t_result mk_result(t_cmd cmd, logic [IW-1:0] tgt, logic [IW-1:0] src);
        t_result res;
        res         = '0;
        res.command = cmd;
        res.target  = VID_W'(tgt);
        res.source  = VID_W'(src);
        return res;
    endfunction

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        vc_ext = {3'b000, r_vcount};
        if (vc_ext == 8'd0) begin
            eff_cnt = CW'(1);
        end else if (vc_ext > 8'(VOICES)) begin
            eff_cnt = CW'(VOICES);
        end else begin
            eff_cnt = CW'(vc_ext);
        end
    end

    assign ent      = r_rd_vld ? r_rdata : '0;
    assign ev       = (r_state == S_SCAN) && r_tag;
    assign last_chk = (r_chk == r_len - CW'(1));
    assign addr_nx  = (CW'(r_addr) == r_len - CW'(1)) ? '0 : r_addr + IW'(1);
    assign cand     = ent.keydown && (r_ridx != r_v) && (!r_found || (ent.note > r_high));

    always_comb begin
        dn_entry           = r_vcap;
        dn_entry.note      = r_pitch;
        dn_entry.vel       = r_vel;
        dn_entry.keydown   = 1'b1;
        dn_entry.sustained = r_pedal;
    end

    always_comb begin
        n_state   = r_state;
        go_scan   = 1'b0;
        go_mode   = r_mode;
        go_start  = '0;
        go_len    = eff_cnt;
        mem_we    = 1'b0;
        mem_wa    = r_ridx;
        mem_wd    = ent;
        push_req  = 1'b0;
        push_last = 1'b0;
        mark      = 1'b0;
        push_item = mk_result(CMD_NONE, '0, '0);
        match     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (q_empty) begin
                    case (r_op)
                        OP_NOTE_ON: begin
                            go_scan = 1'b1;
                            if (r_vel != '0) begin
                                go_mode  = M_DN_FIND;
                                go_start = r_next;
                            end else begin
                                go_mode = M_UP_FIND;
                            end
                        end
                        OP_NOTE_OFF: begin
                            go_scan = 1'b1;
                            go_mode = M_UP_FIND;
                        end
                        OP_PEDAL: begin
                            if (r_pedalv > PEDAL_THRESH) begin
                                n_state = S_FINISH;
                            end else begin
                                go_scan = 1'b1;
                                go_mode = M_PEDAL;
                            end
                        end
                        OP_ALL_SOUND_OFF: begin
                            go_scan = 1'b1;
                            go_mode = M_SOUND_OFF;
                            go_len  = CW'(VOICES);
                        end
                        OP_ALL_NOTES_OFF: begin
                            go_scan = 1'b1;
                            go_mode = M_NOTES_OFF;
                            go_len  = CW'(VOICES);
                        end
                        OP_VOICE_SILENT: begin
                            if (!r_mono && (8'(r_silent) < 8'(eff_cnt))) begin
                                go_scan  = 1'b1;
                                go_mode  = M_SILENT;
                                go_start = IW'(r_silent);
                                go_len   = CW'(1);
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (ev) begin
                    case (r_mode)
                        M_UP_FIND: begin
                            match = ent.keydown && (ent.note == r_pitch);
                            if (match) begin
                                if (r_mono) begin
                                    go_scan = 1'b1;
                                    go_mode = M_UP_MONO;
                                end else begin
                                    n_state = S_UP_VWR;
                                end
                            end else if (last_chk) begin
                                n_state = S_FINISH;
                            end
                        end
                        M_UP_MONO: begin
                            if (last_chk) begin
                                n_state = S_UP_VWR;
                            end
                        end
                        M_DN_FIND: begin
                            match = !ent.keydown;
                            if (match || last_chk) begin
                                n_state = S_DN_START;
                            end
                        end
                        M_DN_MONO: begin
                            match = ent.live;
                            if (match) begin
                                if (!ent.keydown) begin
                                    mem_we      = 1'b1;
                                    mem_wd.live = 1'b0;
                                    push_req    = 1'b1;
                                    push_item   = mk_result(CMD_XSIG, r_v, r_ridx);
                                    n_state     = S_DN_LIVE;
                                end else if (ent.note < r_pitch) begin
                                    mem_we      = 1'b1;
                                    mem_wd.live = 1'b0;
                                    push_req    = 1'b1;
                                    push_item   = mk_result(CMD_XSTATE, r_v, r_ridx);
                                    n_state     = S_DN_LIVE;
                                end else begin
                                    n_state = S_FINISH;
                                end
                            end else if (last_chk) begin
                                n_state = S_DN_LIVE;
                            end
                        end
                        M_PEDAL: begin
                            if (ent.sustained && !ent.keydown) begin
                                mem_we           = 1'b1;
                                mem_wd.sustained = 1'b0;
                                push_req         = 1'b1;
                                push_item        = mk_result(CMD_RELEASE, r_ridx, '0);
                            end
                            if (last_chk) begin
                                n_state = S_FINISH;
                            end
                        end
                        M_SOUND_OFF: begin
                            if (ent.live) begin
                                mem_we           = 1'b1;
                                mem_wd.keydown   = 1'b0;
                                mem_wd.sustained = 1'b0;
                                mem_wd.live      = 1'b0;
                                push_req         = 1'b1;
                                push_item        = mk_result(CMD_SYNC, r_ridx, '0);
                            end
                            if (last_chk) begin
                                n_state = S_FINISH;
                            end
                        end
                        M_NOTES_OFF: begin
                            if (ent.live && ent.keydown) begin
                                mem_we         = 1'b1;
                                mem_wd.keydown = 1'b0;
                            end
                            if (last_chk) begin
                                n_state = S_FINISH;
                            end
                        end
                        M_SILENT: begin
                            if (ent.live) begin
                                mem_we           = 1'b1;
                                mem_wd.keydown   = 1'b0;
                                mem_wd.sustained = 1'b0;
                                mem_wd.live      = 1'b0;
                            end
                            if (last_chk) begin
                                n_state = S_FINISH;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_UP_VWR: begin
                mem_we           = 1'b1;
                mem_wa           = r_v;
                mem_wd           = r_vcap;
                mem_wd.keydown   = 1'b0;
                mem_wd.sustained = r_pedal | r_vcap.sustained;
                if (r_mono && r_found) begin
                    mem_wd.live = 1'b0;
                    push_req    = 1'b1;
                    push_item   = mk_result(CMD_XSTATE, r_t, r_v);
                end
                n_state = S_UP_TWR;
            end
            S_UP_TWR: begin
                if (r_mono && r_found) begin
                    mem_we      = 1'b1;
                    mem_wa      = r_t;
                    mem_wd      = r_tcap;
                    mem_wd.live = 1'b1;
                end
                if (!r_pedal) begin
                    push_req  = 1'b1;
                    push_item = mk_result(CMD_RELEASE, r_v, '0);
                end
                n_state = S_FINISH;
            end
            S_DN_START: begin
                if (r_hit) begin
                    mem_we          = 1'b1;
                    mem_wa          = r_v;
                    mem_wd          = dn_entry;
                    push_req        = 1'b1;
                    push_item       = mk_result(CMD_START, r_v, '0);
                    push_item.pitch = r_pitch;
                    push_item.vel   = r_vel;
                end
                n_state = S_DN_SYNC;
            end
            S_DN_SYNC: begin
                if (r_hit && r_osc) begin
                    push_req  = 1'b1;
                    push_item = mk_result(CMD_SYNC, r_v, '0);
                end
                n_state = S_DN_LFO;
            end
            S_DN_LFO: begin
                if (r_busy0) begin
                    push_req  = 1'b1;
                    push_item = mk_result(CMD_LFO, r_v, '0);
                end
                if (r_mono) begin
                    go_scan = 1'b1;
                    go_mode = M_DN_MONO;
                end else begin
                    n_state = S_DN_LIVE;
                end
            end
            S_DN_LIVE: begin
                mem_we      = 1'b1;
                mem_wa      = r_v;
                mem_wd      = r_vcap;
                mem_wd.live = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (r_nres == '0) begin
                    push_req  = 1'b1;
                    push_last = 1'b1;
                end else begin
                    mark = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (go_scan) begin
            n_state = S_SCAN;
        end
    end

    assign scan_end = ev && (go_scan || (n_state != S_SCAN));
    assign rd_en    = (r_state == S_SCAN) && (r_iss < r_len) && !scan_end;
    assign push_ok  = push_req && (r_nres < RES_CNT_W'(MAX_RESULTS));

    assign q_ctl.push      = push_ok;
    assign q_ctl.push_last = push_last;
    assign q_ctl.mark_last = mark;
    assign q_ctl.hold      = !((r_state == S_IDLE) || (r_state == S_WAIT));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_UP_FIND;
            r_vcount    <= VCOUNT_RESET;
            r_transpose <= TRANSPOSE_RESET;
            r_mono      <= 1'b0;
            r_osc       <= 1'b0;
            r_next      <= '0;
            r_pedal     <= 1'b0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_tag       <= 1'b0;
            r_iss       <= '0;
            r_chk       <= '0;
            r_len       <= CW'(1);
            r_hit       <= 1'b0;
            r_found     <= 1'b0;
            r_busy0     <= 1'b0;
            r_nres      <= '0;
        end else begin
            r_state  <= n_state;
            r_tag    <= rd_en;
            r_rd_vld <= r_vld[r_addr];
            if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            if (i_cfg_wr_en) begin
                case (t_cfg'(i_cfg_index))
                    CFG_VOICE_COUNT: begin
                        r_vcount <= i_cfg_data[VCOUNT_W-1:0];
                        r_next   <= '0;
                    end
                    CFG_TRANSPOSE: begin
                        r_transpose <= i_cfg_data;
                    end
                    CFG_MONO_MODE: begin
                        r_mono <= i_cfg_data[0];
                    end
                    CFG_OSC_SYNC: begin
                        r_osc <= i_cfg_data[0];
                    end
                    default: begin
                        r_osc <= r_osc;
                    end
                endcase
            end
            if ((r_state == S_WAIT) && q_empty && (r_op == OP_PEDAL)) begin
                r_pedal <= (r_pedalv > PEDAL_THRESH);
            end
            if (in_acc) begin
                r_nres <= '0;
            end else if (push_ok) begin
                r_nres <= r_nres + RES_CNT_W'(1);
            end
            if (go_scan) begin
                r_mode  <= go_mode;
                r_len   <= go_len;
                r_iss   <= '0;
                r_chk   <= '0;
                r_found <= 1'b0;
                if (go_mode == M_DN_FIND) begin
                    r_hit   <= 1'b0;
                    r_busy0 <= 1'b0;
                end
            end else begin
                if (rd_en) begin
                    r_iss <= r_iss + CW'(1);
                end
                if (ev) begin
                    r_chk <= r_chk + CW'(1);
                end
                if (ev && (r_mode == M_UP_MONO) && cand) begin
                    r_found <= 1'b1;
                end
                if (ev && (r_mode == M_DN_FIND) && match) begin
                    r_hit   <= 1'b1;
                    r_busy0 <= (r_chk == '0);
                end
            end
            if ((r_state == S_DN_START) && r_hit) begin
                r_next <= (CW'(r_v) == eff_cnt - CW'(1)) ? '0 : r_v + IW'(1);
            end
        end
    end

    // item fields and scan datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= t_op'(i_operation);
            r_pitch  <= NOTE_W'({1'b0, i_key}) + NOTE_W'(r_transpose) - TRANSPOSE_BIAS;
            r_vel    <= i_velocity;
            r_pedalv <= i_pedal_value;
            r_silent <= i_silent_voice;
        end
        if (go_scan) begin
            r_addr <= go_start;
        end else if (rd_en) begin
            r_addr <= addr_nx;
        end
        if (ev && (r_mode == M_UP_FIND) && match) begin
            r_v    <= r_ridx;
            r_vcap <= ent;
        end
        if (ev && (r_mode == M_UP_MONO) && cand) begin
            r_t    <= r_ridx;
            r_tcap <= ent;
            r_high <= ent.note;
        end
        if (ev && (r_mode == M_DN_FIND) && (match || (r_chk == '0))) begin
            r_v    <= r_ridx;
            r_vcap <= ent;
        end
        if ((r_state == S_DN_START) && r_hit) begin
            r_vcap <= dn_entry;
        end
    end

    // voice table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[r_addr];
        r_ridx  <= r_addr;
    end

    pva_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (q_ctl),
        .i_item      (push_item),
        .i_pop_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_empty     (q_empty),
        .o_item      (q_item),
        .o_last      (o_last)
    );

    assign o_command        = q_item.command;
    assign o_target_voice   = q_item.target;
    assign o_source_voice   = q_item.source;
    assign o_voice_pitch    = q_item.pitch;
    assign o_voice_velocity = q_item.vel;

endmodule

### rtl/pva_result_queue.sv
// result queue of the voice allocator: holds the commands of one item
// the newest entry is held back until its last flag is settled
// depends on pva_pkg
module pva_result_queue import pva_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qctl   i_ctl,
    input  t_result i_item,
    input  logic    i_pop_ready,
    output logic    o_valid,
    output logic    o_empty,
    output t_result o_item,
    output logic    o_last
);

    t_result                r_buf [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] r_last;
    logic [RES_PTR_W-1:0]   r_wp;
    logic [RES_PTR_W-1:0]   r_rp;
    logic [RES_CNT_W-1:0]   r_cnt;
    logic                   pop;

    assign o_empty = (r_cnt == '0);
    assign o_valid = (r_cnt > RES_CNT_W'(1)) || ((r_cnt == RES_CNT_W'(1)) && !i_ctl.hold);
    assign pop     = o_valid && i_pop_ready;
    assign o_item  = r_buf[r_rp];
    assign o_last  = r_last[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wp <= r_wp + RES_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + RES_PTR_W'(1);
            end
            case ({i_ctl.push, pop})
                2'b10: begin
                    r_cnt <= r_cnt + RES_CNT_W'(1);
                end
                2'b01: begin
                    r_cnt <= r_cnt - RES_CNT_W'(1);
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_buf[r_wp]  <= i_item;
            r_last[r_wp] <= i_ctl.push_last;
        end else if (i_ctl.mark_last) begin
            r_last[r_wp - RES_PTR_W'(1)] <= 1'b1;
        end
    end

endmodule
